// ----- rtl/core/linear_queue_with_replace_macros.svh -----
// Assertion macros for the linear queue core.
// Depends on a clock named clk and a synchronous reset named rst in the using module.
`ifndef LINEAR_QUEUE_WITH_REPLACE_MACROS_SVH
`define LINEAR_QUEUE_WITH_REPLACE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LQR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LQR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lqr_pkg.sv -----
// Shared constants for the linear queue core: depth default, data width, action and status codes.
// No dependencies.
package lqr_pkg;

  localparam int LQR_DEPTH = 8;
  localparam int DATA_W    = 32;

  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_DISP = 2'd2;
  localparam logic [1:0] ACT_REP  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

// ----- rtl/core/lqr_if.sv -----
// Valid/ready channel interfaces for the linear queue: command words in, response words out.
// Depends on lqr_pkg.
interface lqr_cmd_if import lqr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] new_value;

  modport source (output valid, output action, output value, output new_value, input ready);
  modport sink   (input valid, input action, input value, input new_value, output ready);
endinterface

interface lqr_rsp_if import lqr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ----- rtl/core/lqr_store.sv -----
// Entry store for the linear queue: one write port, one read port with registered data.
// Depends on lqr_pkg.
module lqr_store import lqr_pkg::*; #(
  parameter int DEPTH = LQR_DEPTH,
  parameter int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [IDXW-1:0]          waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic                     re,
  input  logic [IDXW-1:0]          raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/linear_queue_with_replace.sv -----
// Top level of the linear queue with replace: sequencer, head and fill counters, output register.
// Depends on lqr_pkg, lqr_if, lqr_store and linear_queue_with_replace_macros.svh.
//
//   channel  dir  fields                        word
//   cmd      in   action, value, new_value      one command
//   rsp      out  status, data, last            one result; display gives one per live entry
//
// Enqueue writes the entry and answers; dequeue reads the head entry, then answers.
// Display reads and answers each live entry in turn; replace reads entries from the head
// until the first match, which it overwrites with new_value, or until the last live entry.
// All reads use the single store read port; an empty or full answer needs no read.
// rst is synchronous; it empties the queue, entry contents are left as they are.
// A stalled rsp holds the sequencer; cmd is not ready until the last word is taken.
`include "linear_queue_with_replace_macros.svh"

module linear_queue_with_replace import lqr_pkg::*; #(
  parameter int DEPTH = LQR_DEPTH
) (
  input logic       clk,
  input logic       rst,
  lqr_cmd_if.sink   cmd,
  lqr_rsp_if.source rsp
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_t;

  state_t                   state;
  logic [1:0]               act;
  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W-1:0] new_val;
  logic [CNTW-1:0]          head;
  logic [CNTW-1:0]          wcount;
  logic [CNTW-1:0]          ptr;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     last;

  logic                     accept;
  logic                     empty;
  logic                     full;
  logic [CNTW-1:0]          ptr_inc;
  logic                     at_tail;
  logic                     match;
  logic                     we;
  logic [IDXW-1:0]          waddr;
  logic signed [DATA_W-1:0] wdata;
  logic                     re;
  logic [IDXW-1:0]          raddr;
  logic signed [DATA_W-1:0] rdata;

  lqr_store #(.DEPTH(DEPTH), .IDXW(IDXW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmd.ready  = (state == S_IDLE);
  assign rsp.valid  = (state == S_EMIT);
  assign rsp.status = status;
  assign rsp.data   = data;
  assign rsp.last   = last;

  assign accept  = cmd.valid && cmd.ready;
  assign empty   = (head >= wcount);
  assign full    = (wcount == CNTW'(DEPTH));
  assign ptr_inc = ptr + 1'b1;
  assign at_tail = (ptr_inc == wcount);
  assign match   = (rdata == val);

  always_comb begin
    we    = 1'b0;
    waddr = wcount[IDXW-1:0];
    wdata = cmd.value;
    re    = 1'b0;
    raddr = head[IDXW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.action == ACT_ENQ) begin
            we = !full;
          end else begin
            re = !empty;
          end
        end
      end
      S_READ: begin
        raddr = ptr_inc[IDXW-1:0];
        if (act == ACT_REP) begin
          if (match) begin
            we    = 1'b1;
            waddr = ptr[IDXW-1:0];
            wdata = new_val;
          end else begin
            re = !at_tail;
          end
        end
      end
      S_EMIT: begin
        raddr = ptr_inc[IDXW-1:0];
        re    = rsp.ready && (act == ACT_DISP) && !last;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      wcount <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act     <= cmd.action;
            val     <= cmd.value;
            new_val <= cmd.new_value;
            ptr     <= head;
            data    <= '0;
            last    <= 1'b1;
            unique case (cmd.action) inside
              ACT_ENQ: begin
                status <= full ? ST_FULL : ST_OK;
                if (!full) begin
                  wcount <= wcount + 1'b1;
                end
                state <= S_EMIT;
              end
              ACT_DEQ, ACT_DISP: begin
                status <= ST_EMPTY;
                state  <= empty ? S_EMIT : S_READ;
              end
              default: begin
                status <= ST_NOTFOUND;
                state  <= empty ? S_EMIT : S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          unique case (act) inside
            ACT_DEQ: begin
              status <= ST_OK;
              data   <= rdata;
              last   <= 1'b1;
              head   <= head + 1'b1;
              state  <= S_EMIT;
            end
            ACT_DISP: begin
              status <= ST_OK;
              data   <= rdata;
              last   <= at_tail;
              state  <= S_EMIT;
            end
            default: begin
              data <= '0;
              last <= 1'b1;
              if (match) begin
                status <= ST_OK;
                state  <= S_EMIT;
              end else if (at_tail) begin
                status <= ST_NOTFOUND;
                state  <= S_EMIT;
              end else begin
                ptr <= ptr_inc;
              end
            end
          endcase
        end
        S_EMIT: begin
          if (rsp.ready) begin
            if (act == ACT_DISP && !last) begin
              ptr   <= ptr_inc;
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LQR_ASSERT_NOW(a_head_le_fill, 1'b1, head <= wcount, "head passed write position")
  `LQR_ASSERT_NOW(a_fill_le_depth, 1'b1, wcount <= CNTW'(DEPTH), "fill count beyond depth")
  `LQR_ASSERT_NOW(a_accept_no_pending, accept, !rsp.valid, "command taken with result pending")
  `LQR_ASSERT_NOW(a_error_single, rsp.valid && (rsp.status != ST_OK),
    rsp.last && (rsp.data == '0), "error result not single or carries data")
  `LQR_ASSERT_NEXT(a_last_frees, rsp.valid && rsp.ready && rsp.last, cmd.ready,
    "not ready after final word")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for linear_queue_with_replace: random and directed command words,
// a built-in queue predictor, and an in-order check of every response word.
// Depends on lqr_pkg, lqr_if and the linear_queue_with_replace RTL.
module testbench;
  import lqr_pkg::*;

  localparam int TAIL_ITEMS  = 25;
  localparam int RAND_ITEMS  = 195;
  localparam int STALL_AFTER = 30;
  localparam int STALL_LEN   = 160;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } rsp_word_t;

  logic clk;
  logic rst = 1'b1;

  lqr_cmd_if cmd ();
  lqr_rsp_if rsp ();

  linear_queue_with_replace #(.DEPTH(LQR_DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  cmd_word_t                pending_q[$];
  rsp_word_t                rsp_expect_q[$];
  logic signed [DATA_W-1:0] gen_vals[$];

  logic signed [DATA_W-1:0] q_mem [LQR_DEPTH];
  int                       q_head = 0;
  int                       q_fill = 0;

  int        errors     = 0;
  int        cmds_taken = 0;
  bit        cmd_fire   = 1'b0;
  bit        long_hold  = 1'b0;
  int        send_gap   = 0;
  int        hold_left  = 0;
  cmd_word_t next_cmd;
  rsp_word_t exp_word;

  task automatic note_error(input string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endtask

  task automatic predict_queue(input cmd_word_t c);
    rsp_word_t w;
    bit        hit;
    bit        pushed;
    hit    = 1'b0;
    pushed = 1'b0;
    w      = '{status: ST_OK, data: '0, last: 1'b1};
    case (c.action)
      ACT_ENQ: begin
        if (q_fill >= LQR_DEPTH) w.status = ST_FULL;
        else begin
          q_mem[q_fill] = c.value;
          q_fill++;
        end
      end
      ACT_DEQ: begin
        if (q_head >= q_fill) w.status = ST_EMPTY;
        else begin
          w.data = q_mem[q_head];
          q_head++;
        end
      end
      ACT_DISP: begin
        if (q_head >= q_fill) w.status = ST_EMPTY;
        else begin
          for (int i = q_head; i < q_fill; i++) begin
            w.data = q_mem[i];
            w.last = (i == q_fill - 1);
            rsp_expect_q.push_back(w);
          end
          pushed = 1'b1;
        end
      end
      default: begin
        for (int i = q_head; i < q_fill; i++) begin
          if (!hit && q_mem[i] == c.value) begin
            q_mem[i] = c.new_value;
            hit = 1'b1;
          end
        end
        if (!hit) w.status = ST_NOTFOUND;
      end
    endcase
    if (!pushed) rsp_expect_q.push_back(w);
  endtask

  task automatic add_cmd(input logic [1:0] act, input logic signed [DATA_W-1:0] v,
                         input logic signed [DATA_W-1:0] nv);
    pending_q.push_back('{action: act, value: v, new_value: nv});
    if (act == ACT_ENQ) gen_vals.push_back(v);
    if (act == ACT_REP) gen_vals.push_back(nv);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return $urandom_range(0, 7) - 4;
      3, 4, 5: return (gen_vals.size() != 0) ? gen_vals[$urandom_range(0, gen_vals.size() - 1)]
                                             : $urandom;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    cmd_fire = 1'b0;
    if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        predict_queue('{action: cmd.action, value: cmd.value, new_value: cmd.new_value});
        cmds_taken++;
        cmd_fire = 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        if (rsp_expect_q.size() == 0) begin
          note_error($sformatf("unexpected response: status %0d data %0d last %0b",
                               rsp.status, rsp.data, rsp.last));
        end else begin
          exp_word = rsp_expect_q.pop_front();
          if (rsp.status !== exp_word.status || rsp.data !== exp_word.data ||
              rsp.last !== exp_word.last) begin
            note_error($sformatf(
              "mismatch: expected status %0d data %0d last %0b, got status %0d data %0d last %0b",
              exp_word.status, exp_word.data, exp_word.last, rsp.status, rsp.data, rsp.last));
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd.valid     <= 1'b0;
      cmd.action    <= ACT_ENQ;
      cmd.value     <= '0;
      cmd.new_value <= '0;
    end else if (cmd.valid && !cmd_fire) begin
      // hold the offered word
    end else if (send_gap != 0) begin
      send_gap--;
      cmd.valid <= 1'b0;
    end else if (pending_q.size() != 0) begin
      next_cmd = pending_q.pop_front();
      cmd.action    <= next_cmd.action;
      cmd.value     <= next_cmd.value;
      cmd.new_value <= next_cmd.new_value;
      cmd.valid     <= 1'b1;
      if (pending_q.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0)
        send_gap = $urandom_range(1, 19);
    end else begin
      cmd.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (pending_q.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 18);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !long_hold;
    end
  end

  initial begin
    wait (cmds_taken >= STALL_AFTER);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (STALL_LEN) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    int pick;

    add_cmd(ACT_DISP, '0, '0);
    add_cmd(ACT_DEQ, '0, '0);
    add_cmd(ACT_REP, {1'b1, {(DATA_W-1){1'b0}}}, '1);
    add_cmd(ACT_ENQ, {1'b1, {(DATA_W-1){1'b0}}}, '0);
    add_cmd(ACT_ENQ, {1'b0, {(DATA_W-1){1'b1}}}, '1);
    add_cmd(ACT_ENQ, {1'b1, {(DATA_W-1){1'b0}}}, '0);
    add_cmd(ACT_ENQ, '0, '0);
    add_cmd(ACT_DISP, '1, '1);
    add_cmd(ACT_REP, {1'b1, {(DATA_W-1){1'b0}}}, '1);
    add_cmd(ACT_DISP, '0, '0);
    add_cmd(ACT_REP, 32'sd12345, 32'sd1);
    add_cmd(ACT_DEQ, '1, '1);
    add_cmd(ACT_REP, {1'b0, {(DATA_W-1){1'b1}}}, {1'b0, {(DATA_W-1){1'b1}}});
    add_cmd(ACT_DISP, '0, '0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       add_cmd(ACT_ENQ, rand_word(), $urandom);
      else if (pick < 20) add_cmd(ACT_DEQ, $urandom, $urandom);
      else if (pick < 52) add_cmd(ACT_DISP, $urandom, $urandom);
      else                add_cmd(ACT_REP, rand_word(), rand_word());
    end

    // drive the queue to full, drain it, then show it stays full
    repeat (LQR_DEPTH + 1) add_cmd(ACT_ENQ, $urandom, $urandom);
    add_cmd(ACT_DISP, '0, '0);
    repeat (LQR_DEPTH + 1) add_cmd(ACT_DEQ, '0, '0);
    add_cmd(ACT_ENQ, '1, '1);
    add_cmd(ACT_DISP, '0, '0);
    add_cmd(ACT_REP, '1, '0);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || cmd.valid || rsp_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (rsp_expect_q.size() != 0)
      note_error($sformatf("%0d expected responses never arrived", rsp_expect_q.size()));

    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
